// ===== sv/ldh_pkg.sv =====
`timescale 1ns / 1ps

package ldh_pkg;

   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   localparam logic [7:0] NAME_LEN_SAT  = 8'hFF;
   localparam logic [6:0] LABEL_LEN_SAT = 7'h7F;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } ldh_beat_type;

   function automatic logic is_alnum(input logic [7:0] c);
      is_alnum = (c >= 8'h61 && c <= 8'h7A) ||
                 (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h30 && c <= 8'h39);
   endfunction

endpackage

// ===== sv/ldh_in_stage.sv =====
`timescale 1ns / 1ps

module ldh_in_stage
   import ldh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_ch,
   input  logic         req_last,
   input  logic         take,
   output logic         beat_valid,
   output ldh_beat_type beat
);

   logic         vld_ff, vld_in;
   ldh_beat_type beat_ff;

   assign req_stall  = vld_ff && !take;
   assign beat_valid = vld_ff;
   assign beat       = beat_ff;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         beat_ff.ch   <= req_ch;
         beat_ff.last <= req_last;
      end
   end

endmodule

// ===== sv/ldh_scan.sv =====
`timescale 1ns / 1ps

module ldh_scan
   import ldh_pkg::*;
#(
   parameter int MAX_NAME_LEN  = 253,
   parameter int MAX_LABEL_LEN = 63
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  ldh_beat_type beat,
   output logic         result
);

   logic [7:0] name_len_ff, name_len_in;
   logic [6:0] label_len_ff, label_len_in;
   logic       prev_hyphen_ff, prev_hyphen_in;
   logic       star_ff, star_in;
   logic       failed_ff, failed_in;

   logic [8:0] nlen;
   logic [7:0] llen;
   logic       is_dot, is_hyphen, lead_star;

   always_comb begin
      nlen      = {1'b0, name_len_ff} + 9'd1;
      llen      = {1'b0, label_len_ff} + 8'd1;
      is_dot    = (beat.ch == CH_DOT);
      is_hyphen = (beat.ch == CH_HYPHEN);
      lead_star = (beat.ch == CH_STAR) && (name_len_ff == 8'd0);

      failed_in = failed_ff;
      star_in   = star_ff;
      if (nlen > 9'(MAX_NAME_LEN)) begin
         failed_in = 1'b1;
      end
      if (name_len_ff == 8'd1 && star_ff && !is_dot) begin
         failed_in = 1'b1;
      end

      if (is_dot) begin
         if (label_len_ff == 7'd0 || prev_hyphen_ff) begin
            failed_in = 1'b1;
         end
         label_len_in = 7'd0;
      end else begin
         if (label_len_ff == 7'd0 && is_hyphen) begin
            failed_in = 1'b1;
         end
         if (lead_star) begin
            star_in = 1'b1;
         end
         if (!(is_alnum(beat.ch) || is_hyphen || lead_star)) begin
            failed_in = 1'b1;
         end
         if (llen > 8'(MAX_LABEL_LEN)) begin
            failed_in = 1'b1;
         end
         label_len_in = llen[7] ? LABEL_LEN_SAT : llen[6:0];
      end

      prev_hyphen_in = is_hyphen;
      name_len_in    = nlen[8] ? NAME_LEN_SAT : nlen[7:0];

      result = !failed_in && (label_len_in != 7'd0) && !prev_hyphen_in &&
               !(star_in && name_len_in <= 8'd2);
   end

   always_ff @(posedge clock) begin
      if (reset || (step && beat.last)) begin
         name_len_ff    <= 8'd0;
         label_len_ff   <= 7'd0;
         prev_hyphen_ff <= 1'b0;
         star_ff        <= 1'b0;
         failed_ff      <= 1'b0;
      end else if (step) begin
         name_len_ff    <= name_len_in;
         label_len_ff   <= label_len_in;
         prev_hyphen_ff <= prev_hyphen_in;
         star_ff        <= star_in;
         failed_ff      <= failed_in;
      end
   end

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      step && beat.last |=> name_len_ff == 8'd0 && !failed_ff)
      else $error("state not cleared after last beat");

   a_fail_sticky : assert property (@(posedge clock) disable iff (reset)
      step && !beat.last && failed_ff |=> failed_ff)
      else $error("failure flag dropped inside a name");

   a_label_in_name : assert property (@(posedge clock) disable iff (reset)
      {1'b0, label_len_ff} <= name_len_ff)
      else $error("label longer than name");

   a_empty_state : assert property (@(posedge clock) disable iff (reset)
      name_len_ff == 8'd0 |-> label_len_ff == 7'd0 && !star_ff && !prev_hyphen_ff)
      else $error("stale state at start of name");

endmodule

// ===== sv/ldh_rsp_stage.sv =====
`timescale 1ns / 1ps

module ldh_rsp_stage (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic res,
   input  logic rsp_stall,
   output logic rsp_valid,
   output logic rsp_valid_res,
   output logic free
);

   logic vld_ff, vld_in;
   logic res_ff;

   assign rsp_valid     = vld_ff;
   assign rsp_valid_res = res_ff;
   assign free          = !vld_ff || !rsp_stall;

   always_comb begin
      vld_in = vld_ff && rsp_stall;
      if (load) begin
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

endmodule

// ===== sv/ldh_domain_name_checker_unit.sv =====
`timescale 1ns / 1ps
// channel | ports                          | beat taken when
// req     | req_valid req_stall req_ch/last | req_valid && !req_stall
// rsp     | rsp_valid rsp_stall rsp_valid_res | rsp_valid && !rsp_stall
// one byte per cycle unless a last byte waits on rsp_stall; input is registered
// a last byte's result is registered in the output register as the byte is taken
// the name state counters update once per byte taken, no iteration
// reset is synchronous, active high, and clears all name state and valids
// rsp_stall holds back only last bytes; other bytes keep flowing under a stall

module ldh_domain_name_checker_unit
   import ldh_pkg::*;
#(
   parameter int MAX_NAME_LEN  = 253,
   parameter int MAX_LABEL_LEN = 63
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res
);

   ldh_beat_type beat;
   logic         beat_valid, take, out_free, result;

   assign take = beat_valid && (!beat.last || out_free);

   ldh_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_ch     (req_ch),
      .req_last   (req_last),
      .take       (take),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   ldh_scan #(
      .MAX_NAME_LEN  (MAX_NAME_LEN),
      .MAX_LABEL_LEN (MAX_LABEL_LEN)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .beat   (beat),
      .result (result)
   );

   ldh_rsp_stage u_rsp (
      .clock         (clock),
      .reset         (reset),
      .load          (take && beat.last),
      .res           (result),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_valid_res (rsp_valid_res),
      .free          (out_free)
   );

endmodule

// ===== bench/ldh_domain_name_checker_unit_tb.sv =====
`timescale 1ns / 1ps

module ldh_domain_name_checker_unit_tb;
   import ldh_pkg::*;

   localparam int NAME_LIMIT  = 253;
   localparam int LABEL_LIMIT = 63;
   localparam int BYTE_TARGET = 1750;
   localparam int IDLE_LIMIT  = 300;
   localparam int TAIL_CYCLES = 8;
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TOP = 8'hFF;

   typedef enum int {
      FLAW_RANDOM,
      FLAW_HYPHEN,
      FLAW_DOT,
      FLAW_STAR,
      FLAW_NUL,
      FLAW_TRAILING_DOT,
      FLAW_COUNT
   } flaw_kind_type;

   typedef struct {
      logic [7:0] ch;
      logic       fin;
      int         gap;
      bit         drain;
   } name_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_valid_res;

   name_byte_type name_bytes_q[$];
   logic       verdicts_q[$];
   logic [7:0] draft[$];
   int         label_lens[$];

   // checker state as seen by the predictor
   logic [7:0] seen_len;
   logic [6:0] label_len;
   logic       after_hyphen;
   logic       star_lead;
   logic       broken;

   int  mismatches = 0;
   int  queued_bytes = 0;
   int  names_ok = 0;
   int  names_bad = 0;
   int  idle_cycles = 0;
   int  gap_left = 0;
   bit  gap_armed = 0;
   int  hold_left = 0;
   bit  rsp_calm = 0;
   bit  calm = 0;
   logic want;
   name_byte_type next_beat;

   ldh_domain_name_checker_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic clear_name_state();
      seen_len     = 8'd0;
      label_len    = 7'd0;
      after_hyphen = 1'b0;
      star_lead    = 1'b0;
      broken       = 1'b0;
   endtask

   task automatic predict_name_byte(input logic [7:0] c, input logic fin);
      int   count_next;
      int   lab_next;
      int   pos;
      logic char_ok;
      logic verdict;
      pos = seen_len;
      count_next = int'(seen_len) + 1;
      if (count_next > NAME_LIMIT) broken = 1'b1;
      if (pos == 1 && star_lead && c != CH_DOT) broken = 1'b1;
      if (c == CH_DOT) begin
         if (label_len == 0 || after_hyphen) broken = 1'b1;
         label_len = 7'd0;
      end else begin
         if (label_len == 0 && c == CH_HYPHEN) broken = 1'b1;
         char_ok = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9") || c == CH_HYPHEN;
         if (c == CH_STAR && pos == 0) begin
            star_lead = 1'b1;
            char_ok = 1'b1;
         end
         if (!char_ok) broken = 1'b1;
         lab_next = int'(label_len) + 1;
         if (lab_next > LABEL_LIMIT) broken = 1'b1;
         label_len = (lab_next > 127) ? 7'd127 : 7'(lab_next);
      end
      after_hyphen = (c == CH_HYPHEN);
      seen_len = (count_next > 255) ? 8'd255 : 8'(count_next);
      if (fin) begin
         verdict = !broken && label_len != 0 && !after_hyphen;
         if (star_lead && seen_len <= 2) verdict = 1'b0;
         verdicts_q.push_back(verdict);
         if (verdict) names_ok++;
         else names_bad++;
         clear_name_state();
      end
   endtask

   function automatic logic [7:0] ldh_char(input bit inner);
      int pick;
      pick = $urandom_range(0, inner ? 9 : 7);
      if (pick < 3) return 8'(8'h61 + $urandom_range(0, 25));
      if (pick < 5) return 8'(8'h41 + $urandom_range(0, 25));
      if (pick < 8) return 8'(8'h30 + $urandom_range(0, 9));
      return CH_HYPHEN;
   endfunction

   task automatic draft_text(input string s);
      int k;
      draft.delete();
      for (k = 0; k < s.len(); k++) draft.push_back(s[k]);
   endtask

   task automatic draft_labels(input bit star);
      int k;
      int j;
      draft.delete();
      if (star) begin
         draft.push_back(CH_STAR);
         draft.push_back(CH_DOT);
      end
      for (k = 0; k < label_lens.size(); k++) begin
         if (k > 0) draft.push_back(CH_DOT);
         for (j = 0; j < label_lens[k]; j++)
            draft.push_back(ldh_char(j > 0 && j < label_lens[k] - 1));
      end
   endtask

   task automatic spoil_draft();
      int            at;
      flaw_kind_type flaw;
      at = $urandom_range(0, draft.size() - 1);
      flaw = flaw_kind_type'($urandom_range(0, FLAW_COUNT - 1));
      case (flaw)
         FLAW_RANDOM: draft[at] = 8'($urandom_range(0, 255));
         FLAW_HYPHEN: draft[at] = CH_HYPHEN;
         FLAW_DOT:    draft[at] = CH_DOT;
         FLAW_STAR:   draft[at] = CH_STAR;
         FLAW_NUL:    draft[at] = CH_NUL;
         default:     draft.push_back(CH_DOT);
      endcase
   endtask

   task automatic queue_draft(input bit drain);
      name_byte_type b;
      int            k;
      for (k = 0; k < draft.size(); k++) begin
         b.ch    = draft[k];
         b.fin   = (k == draft.size() - 1);
         b.gap   = calm ? 0 : $urandom_range(0, 4);
         b.drain = drain && k == 0;
         name_bytes_q.push_back(b);
      end
      queued_bytes += draft.size();
   endtask

   task automatic queue_text(input string s, input bit drain);
      draft_text(s);
      queue_draft(drain);
   endtask

   task automatic queue_lone_byte(input logic [7:0] c);
      draft.delete();
      draft.push_back(c);
      queue_draft(0);
   endtask

   task automatic pick_long_shape();
      label_lens.delete();
      case ($urandom_range(0, 5))
         0: label_lens = '{LABEL_LIMIT};
         1: label_lens = '{LABEL_LIMIT + 1};
         2: label_lens = '{LABEL_LIMIT, LABEL_LIMIT, LABEL_LIMIT, NAME_LIMIT - 192};
         3: label_lens = '{LABEL_LIMIT, LABEL_LIMIT, LABEL_LIMIT, NAME_LIMIT - 191};
         4: label_lens = '{LABEL_LIMIT, LABEL_LIMIT, LABEL_LIMIT, LABEL_LIMIT, LABEL_LIMIT};
         default: label_lens = '{130};
      endcase
   endtask

   // stimulus
   initial begin
      int n;
      int k;
      int roll;
      clear_name_state();
      queue_text("a", 0);
      queue_text("*", 0);
      queue_text("*.", 0);
      queue_text("*.a", 0);
      queue_text("*a", 0);
      queue_text("-a", 0);
      queue_text("a-", 0);
      queue_text("a..b", 1);
      queue_text("a.", 0);
      queue_text("a*b", 0);
      queue_lone_byte(CH_NUL);
      queue_lone_byte(CH_TOP);
      while (queued_bytes < BYTE_TARGET) begin
         if ($urandom_range(0, 29) == 0) calm = !calm;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            pick_long_shape();
            draft_labels($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) spoil_draft();
         end else if (roll < 13) begin
            draft.delete();
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) draft.push_back(8'($urandom_range(0, 255)));
         end else begin
            label_lens.delete();
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 19) == 0)
                  label_lens.push_back($urandom_range(LABEL_LIMIT - 8, LABEL_LIMIT + 7));
               else
                  label_lens.push_back($urandom_range(1, 6));
            end
            draft_labels($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0) spoil_draft();
         end
         queue_draft($urandom_range(0, 24) == 0);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (name_bytes_q.size() != 0 || req_valid) @(posedge clock);
      while (verdicts_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("checked %0d names over %0d bytes", names_ok + names_bad, queued_bytes);
      $display("%0d names accepted and %0d rejected, long names and labels included",
               names_ok, names_bad);
      if (mismatches == 0) begin
         $display("ldh_domain_name_checker_unit verification clean");
      end else begin
         $display("ldh_domain_name_checker_unit verification failed");
      end
      $finish;
   end

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_armed = 0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) predict_name_byte(req_ch, req_last);
         if (!req_valid || !req_stall) begin
            if (!gap_armed && name_bytes_q.size() != 0) begin
               gap_left = name_bytes_q[0].gap;
               gap_armed = 1;
            end
            if (name_bytes_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (name_bytes_q[0].drain && verdicts_q.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               next_beat = name_bytes_q.pop_front();
               gap_armed = 0;
               req_valid <= 1'b1;
               req_ch <= next_beat.ch;
               req_last <= next_beat.fin;
            end
         end
      end
   end

   // verdict monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_q.size() == 0) begin
               $error("valid_res: expected no beat, got %0b", rsp_valid_res);
               mismatches++;
            end else begin
               want = verdicts_q.pop_front();
               if (rsp_valid_res !== want) begin
                  $error("valid_res: expected %0b, got %0b", want, rsp_valid_res);
                  mismatches++;
               end
            end
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
            hold_left = rsp_calm ? 0 : $urandom_range(0, 4);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("ldh_domain_name_checker_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
